FILE: hdl/res_pkg.sv
// ----------------------------------------------------------------------------
// res_pkg: shared definitions for the repeat event suppressor
// Field widths, register indexes, reset values and the per-entry cell
// operation codes used by the table cells and the controller.
// ----------------------------------------------------------------------------
package res_pkg;

	localparam int LEVEL_W        = 3;
	localparam int FILE_W         = 32;
	localparam int LINE_W         = 20;
	localparam int LIMIT_W        = 16;
	localparam int MASK_W         = 8;
	localparam int REPORT_COUNT_W = 16;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 1;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_TIMES_LIMIT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_MASK  = 1'd1;

	localparam logic [LIMIT_W-1:0] TIMES_LIMIT_RESET = 16'd100;
	localparam logic [MASK_W-1:0]  LEVEL_MASK_RESET  = 8'd0;

	// What one table cell does at the next clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LOAD  = 2'd1,
		CELL_SHIFT = 2'd2,
		CELL_INC   = 2'd3
	} cell_op_t;

endpackage : res_pkg

FILE: hdl/res_cell.sv
// ----------------------------------------------------------------------------
// res_cell: one entry of the repeat table
// Holds a file, a line and a saturating repeat count. Compares itself with
// the broadcast key, and loads, increments or takes its right neighbour.
// ----------------------------------------------------------------------------
module res_cell
	import res_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  cell_op_t               op,
	input  logic [FILE_W-1:0]      key_file,
	input  logic [LINE_W-1:0]      key_line,
	input  logic [LIMIT_W-1:0]     limit,
	input  logic [FILE_W-1:0]      nbr_file,
	input  logic [LINE_W-1:0]      nbr_line,
	input  logic [COUNT_WIDTH-1:0] nbr_count,
	output logic [FILE_W-1:0]      file_q,
	output logic [LINE_W-1:0]      line_q,
	output logic [COUNT_WIDTH-1:0] count_q,
	output logic                   match,
	output logic                   over_next
);

	localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	logic [COUNT_WIDTH-1:0] count_inc;

	// The count sticks at all ones.
	assign count_inc = (&count_q) ? count_q : count_q + 1'b1;
	assign match     = (file_q == key_file) && (line_q == key_line);
	assign over_next = CMP_W'(count_inc) > CMP_W'(limit);

	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD: begin
				file_q  <= key_file;
				line_q  <= key_line;
				count_q <= '0;
			end
			CELL_SHIFT: begin
				file_q  <= nbr_file;
				line_q  <= nbr_line;
				count_q <= nbr_count;
			end
			CELL_INC: begin
				count_q <= count_inc;
			end
			default: begin
			end
		endcase
	end

endmodule : res_cell

FILE: hdl/repeat_event_suppressor_core.sv
// ----------------------------------------------------------------------------
// repeat_event_suppressor_core: rate limiter for repeated log events
// Looks each event up in a row of table cells, counts repeats, suppresses
// events over the limit, evicts the least repeated entry when full, and
// reports over-limit entries when a periodic clear falls due.
// ----------------------------------------------------------------------------
// Flow: an event word is taken only in the idle state. Unmasked levels go straight to
// the verdict state; hits and appends pass through the lookup state first; a full-table
// miss adds the lowest-count search and the eviction, and a clear walks the used entries
// in place of the lookup, held while a report waits for room. The next event word is not
// taken until the verdict word has been loaded and the controller is back in idle.
// Reset: arst_n empties the table and loads the register reset values.
module repeat_event_suppressor_core
	import res_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration writes
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	// event channel
	input  logic                       event_valid,
	output logic                       event_ready,
	input  logic [LEVEL_W-1:0]         level,
	input  logic [FILE_W-1:0]          source_file,
	input  logic [LINE_W-1:0]          source_line,
	input  logic                       clear_due,
	// result channel
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic                       is_report,
	output logic                       pass_event,
	output logic [FILE_W-1:0]          report_file,
	output logic [LINE_W-1:0]          report_line,
	output logic [REPORT_COUNT_W-1:0]  report_count,
	output logic                       last
);

	localparam int USED_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CMP_W  = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	// Controller states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_LOOK    = 6'b000010,
		ST_MIN     = 6'b000100,
		ST_EVICT   = 6'b001000,
		ST_CLEAR   = 6'b010000,
		ST_VERDICT = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [LIMIT_W-1:0] times_limit_q;
	logic [MASK_W-1:0]  level_mask_q;

	// The event being worked on.
	logic [FILE_W-1:0] key_file_q;
	logic [LINE_W-1:0] key_line_q;
	logic              pass_q;

	// Table fill and scan bookkeeping.
	logic [USED_W-1:0]      used_q;
	logic [USED_W-1:0]      scan_cnt_q;
	logic [IDX_W-1:0]       scan_idx_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [COUNT_WIDTH-1:0] best_q;

	// Output register.
	logic                      result_valid_q;
	logic                      is_report_q;
	logic                      pass_event_q;
	logic [FILE_W-1:0]         report_file_q;
	logic [LINE_W-1:0]         report_line_q;
	logic [REPORT_COUNT_W-1:0] report_count_q;
	logic                      last_q;

	// Cell row.
	cell_op_t               cell_op    [TABLE_DEPTH];
	logic [FILE_W-1:0]      cell_file  [TABLE_DEPTH];
	logic [LINE_W-1:0]      cell_line  [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] cell_count [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] cell_match;
	logic [TABLE_DEPTH-1:0] cell_over;
	logic [TABLE_DEPTH-1:0] hit_vec;

	logic event_fire;
	logic out_free;
	logic any_hit;
	logic table_full;
	logic head_over;
	logic clear_done;
	logic clear_step;
	logic load_report;
	logic load_verdict;
	logic [COUNT_WIDTH-1:0] scan_count;

	assign event_ready = (state_q == ST_IDLE);
	assign event_fire  = event_valid && event_ready;

	// The output register can take a new word when it is empty or its
	// current word leaves at this edge.
	assign out_free = !result_valid_q || result_ready;

	assign any_hit    = |hit_vec;
	assign table_full = (used_q == USED_W'(TABLE_DEPTH));

	// During a clear the row shifts towards cell 0, so the entry under
	// inspection is always the head cell. A report only goes out when the
	// output register has room; entries under the limit pass through freely.
	assign head_over  = CMP_W'(cell_count[0]) > CMP_W'(times_limit_q);
	assign clear_done = (scan_cnt_q == used_q);
	assign clear_step = (state_q == ST_CLEAR) && !clear_done && (!head_over || out_free);

	assign load_report  = clear_step && head_over;
	assign load_verdict = (state_q == ST_VERDICT) && out_free;

	// Single read port into the row for the lowest-count search.
	assign scan_count = cell_count[scan_idx_q];

	// ------------------------------------------------------------------
	// Cell row: each cell holds one entry and talks to its right-hand
	// neighbour for eviction and clearing shifts.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [FILE_W-1:0]      nbr_file;
		logic [LINE_W-1:0]      nbr_line;
		logic [COUNT_WIDTH-1:0] nbr_count;

		if (i < TABLE_DEPTH - 1) begin : g_nbr
			assign nbr_file  = cell_file[i+1];
			assign nbr_line  = cell_line[i+1];
			assign nbr_count = cell_count[i+1];
		end else begin : g_end
			assign nbr_file  = cell_file[i];
			assign nbr_line  = cell_line[i];
			assign nbr_count = cell_count[i];
		end

		// Only entries below the fill count take part in a lookup.
		assign hit_vec[i] = cell_match[i] && (USED_W'(i) < used_q);

		always_comb begin
			cell_op[i] = CELL_HOLD;
			case (state_q)
				ST_LOOK: begin
					if (any_hit) begin
						if (hit_vec[i]) begin
							cell_op[i] = CELL_INC;
						end
					end else if (!table_full && (used_q == USED_W'(i))) begin
						cell_op[i] = CELL_LOAD;
					end
				end
				ST_EVICT: begin
					// Close the gap left by the victim and append at the end.
					if (i == TABLE_DEPTH - 1) begin
						cell_op[i] = CELL_LOAD;
					end else if (IDX_W'(i) >= best_idx_q) begin
						cell_op[i] = CELL_SHIFT;
					end
				end
				ST_CLEAR: begin
					if (clear_step && (i < TABLE_DEPTH - 1)) begin
						cell_op[i] = CELL_SHIFT;
					end
				end
				default: begin
				end
			endcase
		end

		res_cell #(
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_cell (
			.clk       (clk),
			.op        (cell_op[i]),
			.key_file  (key_file_q),
			.key_line  (key_line_q),
			.limit     (times_limit_q),
			.nbr_file  (nbr_file),
			.nbr_line  (nbr_line),
			.nbr_count (nbr_count),
			.file_q    (cell_file[i]),
			.line_q    (cell_line[i]),
			.count_q   (cell_count[i]),
			.match     (cell_match[i]),
			.over_next (cell_over[i])
		);
	end

	// ------------------------------------------------------------------
	// Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			times_limit_q <= TIMES_LIMIT_RESET;
			level_mask_q  <= LEVEL_MASK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMES_LIMIT: times_limit_q <= cfg_data;
				REG_LEVEL_MASK:  level_mask_q  <= cfg_data[MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Controller.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			scan_cnt_q <= '0;
			scan_idx_q <= '0;
			best_idx_q <= '0;
			pass_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (event_fire) begin
						scan_cnt_q <= '0;
						pass_q     <= 1'b1;
						// Levels without suppression go straight to a
						// passing verdict and leave the table alone.
						if (!level_mask_q[level]) begin
							state_q <= ST_VERDICT;
						end else if (clear_due) begin
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					if (any_hit) begin
						// The matching cell counts up this edge; its
						// incremented count decides the verdict.
						pass_q  <= !(|(hit_vec & cell_over));
						state_q <= ST_VERDICT;
					end else if (!table_full) begin
						used_q  <= used_q + 1'b1;
						state_q <= ST_VERDICT;
					end else begin
						// Table full: seed the search with cell 0.
						best_idx_q <= '0;
						scan_idx_q <= IDX_W'(1);
						state_q    <= ST_MIN;
					end
				end
				ST_MIN: begin
					// Strictly lower only, so ties keep the first entry.
					if (scan_count < best_q) begin
						best_idx_q <= scan_idx_q;
					end
					if (scan_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_EVICT;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_EVICT: begin
					state_q <= ST_VERDICT;
				end
				ST_CLEAR: begin
					if (clear_done) begin
						used_q  <= '0;
						state_q <= ST_VERDICT;
					end else if (clear_step) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				ST_VERDICT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Running minimum of the search; payload only, no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			best_q <= cell_count[0];
		end else if ((state_q == ST_MIN) && (scan_count < best_q)) begin
			best_q <= scan_count;
		end
	end

	// Key capture on acceptance.
	always_ff @(posedge clk) begin
		if (event_fire) begin
			key_file_q <= source_file;
			key_line_q <= source_line;
		end
	end

	// ------------------------------------------------------------------
	// Output register: reports during a clear, then the verdict word.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_report || load_verdict) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_report) begin
			is_report_q   <= 1'b1;
			pass_event_q  <= 1'b0;
			report_file_q <= cell_file[0];
			report_line_q <= cell_line[0];
			// Counts wider than the report field are clipped to its maximum.
			if (CMP_W'(cell_count[0]) > CMP_W'({REPORT_COUNT_W{1'b1}})) begin
				report_count_q <= {REPORT_COUNT_W{1'b1}};
			end else begin
				report_count_q <= REPORT_COUNT_W'(CMP_W'(cell_count[0]));
			end
			last_q <= 1'b0;
		end else if (load_verdict) begin
			is_report_q    <= 1'b0;
			pass_event_q   <= pass_q;
			report_file_q  <= '0;
			report_line_q  <= '0;
			report_count_q <= '0;
			last_q         <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign is_report    = is_report_q;
	assign pass_event   = pass_event_q;
	assign report_file  = report_file_q;
	assign report_line  = report_line_q;
	assign report_count = report_count_q;
	assign last         = last_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// Appends only happen on a miss, so at most one live entry can match.
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> $onehot0(hit_vec))
		else $error("more than one table entry matches the key");

	// The fill count never runs past the table.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	// An eviction keeps the table full.
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) |=> (used_q == USED_W'(TABLE_DEPTH)))
		else $error("table not full after eviction");

	// A finished clear empties the table before the verdict.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CLEAR) && clear_done) |=> (used_q == '0) && (state_q == ST_VERDICT))
		else $error("clear did not empty the table");

	// A report word never closes the sequence of an event.
	a_report_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && is_report_q) |-> (!last_q && !pass_event_q))
		else $error("report word flagged as last or passing");

endmodule : repeat_event_suppressor_core

FILE: dv/res_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// res_checker: scoreboard for the repeat event suppressor
// Watches the register port and both word channels, keeps its own copy of the
// repeat table and registers, predicts the result words of every accepted
// event word and compares each accepted result word with the oldest one due.
// ----------------------------------------------------------------------------
module res_checker
	import res_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      event_valid,
	input  logic                      event_ready,
	input  logic [LEVEL_W-1:0]        level,
	input  logic [FILE_W-1:0]         source_file,
	input  logic [LINE_W-1:0]         source_line,
	input  logic                      clear_due,
	input  logic                      result_valid,
	input  logic                      result_ready,
	input  logic                      is_report,
	input  logic                      pass_event,
	input  logic [FILE_W-1:0]         report_file,
	input  logic [LINE_W-1:0]         report_line,
	input  logic [REPORT_COUNT_W-1:0] report_count,
	input  logic                      last,
	output int                        mismatches,
	output logic                      drained
);

	localparam logic [COUNT_WIDTH-1:0]    COUNT_MAX  = '1;
	localparam logic [REPORT_COUNT_W-1:0] REPORT_MAX = '1;

	typedef struct packed {
		logic                      is_report;
		logic                      pass_event;
		logic [FILE_W-1:0]         file;
		logic [LINE_W-1:0]         line;
		logic [REPORT_COUNT_W-1:0] count;
		logic                      last;
	} result_word_t;

	logic [LIMIT_W-1:0]     times_limit_q;
	logic [MASK_W-1:0]      level_mask_q;
	logic [FILE_W-1:0]      tbl_file  [TABLE_DEPTH];
	logic [LINE_W-1:0]      tbl_line  [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] tbl_count [TABLE_DEPTH];
	int                     tbl_used;
	result_word_t           due_words [$];

	function automatic result_word_t verdict_word(input logic pass);
		result_word_t w;
		w = '0;
		w.pass_event = pass;
		w.last = 1'b1;
		return w;
	endfunction

	function automatic void check_field(input string name, input longint unsigned want_v,
		input longint unsigned got_v);
		if (want_v != got_v) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
		end
	endfunction

	// Works out the result words of one event word and updates the table copy.
	function automatic void predict_event(input logic [LEVEL_W-1:0] lvl,
		input logic [FILE_W-1:0] file, input logic [LINE_W-1:0] line, input logic clr);
		int              hit;
		int              victim;
		longint unsigned cnt_wide;
		result_word_t    w;
		hit = -1;
		if (!level_mask_q[lvl]) begin
			due_words.push_back(verdict_word(1'b1));
			return;
		end
		if (clr) begin
			for (int i = 0; i < tbl_used; i++) begin
				if (tbl_count[i] > times_limit_q) begin
					cnt_wide = 64'(tbl_count[i]);
					w = '0;
					w.is_report = 1'b1;
					w.file = tbl_file[i];
					w.line = tbl_line[i];
					w.count = (cnt_wide > REPORT_MAX) ? REPORT_MAX : REPORT_COUNT_W'(cnt_wide);
					due_words.push_back(w);
				end
			end
			tbl_used = 0;
			due_words.push_back(verdict_word(1'b1));
			return;
		end
		for (int i = 0; i < tbl_used; i++)
			if (hit < 0 && tbl_file[i] == file && tbl_line[i] == line)
				hit = i;
		if (hit >= 0) begin
			if (tbl_count[hit] != COUNT_MAX)
				tbl_count[hit]++;
			due_words.push_back(verdict_word(!(tbl_count[hit] > times_limit_q)));
			return;
		end
		if (tbl_used >= TABLE_DEPTH) begin
			// The first entry holding the lowest count goes; the rest close up.
			victim = 0;
			for (int i = 1; i < TABLE_DEPTH; i++)
				if (tbl_count[i] < tbl_count[victim])
					victim = i;
			for (int i = victim; i < TABLE_DEPTH - 1; i++) begin
				tbl_file[i]  = tbl_file[i+1];
				tbl_line[i]  = tbl_line[i+1];
				tbl_count[i] = tbl_count[i+1];
			end
			tbl_used = TABLE_DEPTH - 1;
		end
		tbl_file[tbl_used]  = file;
		tbl_line[tbl_used]  = line;
		tbl_count[tbl_used] = '0;
		tbl_used++;
		due_words.push_back(verdict_word(1'b1));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		if (!arst_n) begin
			times_limit_q = TIMES_LIMIT_RESET;
			level_mask_q  = LEVEL_MASK_RESET;
			tbl_used      = 0;
			due_words.delete();
			mismatches    = 0;
			drained      <= 1'b1;
		end else begin
			if (result_valid && result_ready) begin
				if (due_words.size() == 0) begin
					mismatches++;
					$display("%0t: result word expected none, got report %0b pass %0b %0h:%0h count %0h",
						$time, is_report, pass_event, report_file, report_line,
						report_count);
				end else begin
					want = due_words.pop_front();
					check_field("is_report", 64'(want.is_report), 64'(is_report));
					check_field("pass_event", 64'(want.pass_event), 64'(pass_event));
					check_field("report_file", 64'(want.file), 64'(report_file));
					check_field("report_line", 64'(want.line), 64'(report_line));
					check_field("report_count", 64'(want.count), 64'(report_count));
					check_field("last", 64'(want.last), 64'(last));
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_TIMES_LIMIT)
					times_limit_q = cfg_data[LIMIT_W-1:0];
				else if (cfg_index == REG_LEVEL_MASK)
					level_mask_q = cfg_data[MASK_W-1:0];
			end
			if (event_valid && event_ready)
				predict_event(level, source_file, source_line, clear_due);
			drained <= (due_words.size() == 0);
		end
	end

endmodule : res_checker

FILE: dv/repeat_event_suppressor_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// repeat_event_suppressor_core_tb: top level of the suppressor testbench
// Drives event words and register writes into the core, stalls the result
// channel, and leaves prediction and comparison to the checker beside it.
// A directed opening and several random phases follow.
// ----------------------------------------------------------------------------
module repeat_event_suppressor_core_tb;
	import res_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	// Longest quiet spell of the core: a full-table scan or a full clear.
	localparam int TAIL_CYCLES = 2 * TABLE_DEPTH_DEF + 8;
	localparam int POOL_MAX    = 32;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_we       = 1'b0;
	logic [CFG_INDEX_W-1:0]    cfg_index    = REG_TIMES_LIMIT;
	logic [CFG_DATA_W-1:0]     cfg_data     = '0;
	logic                      event_valid  = 1'b0;
	logic                      event_ready;
	logic [LEVEL_W-1:0]        level        = '0;
	logic [FILE_W-1:0]         source_file  = '0;
	logic [LINE_W-1:0]         source_line  = '0;
	logic                      clear_due    = 1'b0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic                      is_report;
	logic                      pass_event;
	logic [FILE_W-1:0]         report_file;
	logic [LINE_W-1:0]         report_line;
	logic [REPORT_COUNT_W-1:0] report_count;
	logic                      last;

	int          mismatches;
	logic        drained;
	int          cycle_count = 0;
	// Sender burst state; tx_free turns the gaps off for a whole stretch.
	int          burst_left  = 0;
	bit          tx_free     = 1'b0;
	// Receiver stall pattern; rx_free holds ready high for a whole stretch.
	int          rx_hold     = 0;
	logic        rx_open     = 1'b1;
	logic        rx_free     = 1'b0;
	// Copy of the mask last written, so that random events can aim at it.
	logic [MASK_W-1:0] cur_mask = LEVEL_MASK_RESET;

	repeat_event_suppressor_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.event_valid  (event_valid),
		.event_ready  (event_ready),
		.level        (level),
		.source_file  (source_file),
		.source_line  (source_line),
		.clear_due    (clear_due),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.is_report    (is_report),
		.pass_event   (pass_event),
		.report_file  (report_file),
		.report_line  (report_line),
		.report_count (report_count),
		.last         (last)
	);

	res_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.event_valid  (event_valid),
		.event_ready  (event_ready),
		.level        (level),
		.source_file  (source_file),
		.source_line  (source_line),
		.clear_due    (clear_due),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.is_report    (is_report),
		.pass_event   (pass_event),
		.report_file  (report_file),
		.report_line  (report_line),
		.report_count (report_count),
		.last         (last),
		.mismatches   (mismatches),
		.drained      (drained)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result word ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("repeat_event_suppressor_core_tb: FAIL");
			$finish;
		end
	end

	// The receiver alternates open and stalled spells of random length, with
	// the odd long stall so that reports back up behind a slow consumer.
	always @(posedge clk) begin
		if (rx_hold > 0)
			rx_hold--;
		else begin
			rx_open = !rx_open;
			if (rx_open)
				rx_hold = $urandom_range(0, 7);
			else if ($urandom_range(0, 9) == 0)
				rx_hold = $urandom_range(10, 24);
			else
				rx_hold = $urandom_range(0, 4);
		end
		result_ready <= rx_free || rx_open;
	end

	// Both registers are written back to back, so the enable stays high
	// across both writes. Only called while the core is idle.
	task automatic set_config(input logic [LIMIT_W-1:0] limit,
		input logic [CFG_DATA_W-1:0] mask_data);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TIMES_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_index <= REG_LEVEL_MASK;
		cfg_data  <= mask_data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_mask   = mask_data[MASK_W-1:0];
	endtask

	// Offers one event word and returns at the edge where it is taken. Gaps
	// fall only between bursts, so valid is never dropped and raised again
	// within one time step.
	task automatic offer_event(input logic [LEVEL_W-1:0] lvl, input logic [FILE_W-1:0] file,
		input logic [LINE_W-1:0] line, input logic clr);
		int gap;
		if (!tx_free) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 10);
				burst_left = $urandom_range(1, 16);
				event_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		event_valid <= 1'b1;
		level       <= lvl;
		source_file <= file;
		source_line <= line;
		clear_due   <= clr;
		do @(posedge clk); while (!event_ready);
	endtask

	// Stops sending and waits until every predicted result word has come
	// back. The checker's flag is registered, hence the first wait.
	task automatic settle();
		event_valid <= 1'b0;
		@(posedge clk);
		while (!drained) @(posedge clk);
	endtask

	// One random phase. Most events draw on a small pool of keys, skewed
	// towards the first few so that hits, over-limit counts and evictions all
	// happen; some keys share a file or a line with their neighbour so that
	// both halves of the match are exercised. The rest is full-width noise.
	task automatic run_random_phase(input int n_items, input int pool_size,
		input int clear_pm, input int noise_pct);
		logic [FILE_W-1:0]  pool_file [POOL_MAX];
		logic [LINE_W-1:0]  pool_line [POOL_MAX];
		logic [LEVEL_W-1:0] lvl;
		int                 pick;
		for (int k = 0; k < POOL_MAX; k++) begin
			pool_file[k] = (k % 4 == 1) ? pool_file[k-1] : $urandom();
			pool_line[k] = (k % 4 == 2) ? pool_line[k-1]
				: LINE_W'($urandom_range(0, 20'hFFFFF));
		end
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(0, 99) < noise_pct)
				offer_event(LEVEL_W'($urandom_range(0, 7)), $urandom(),
					LINE_W'($urandom_range(0, 20'hFFFFF)), $urandom_range(0, 19) == 0);
			else begin
				pick = $urandom_range(0, 1) ? $urandom_range(0, 3)
					: $urandom_range(0, pool_size - 1);
				// Prefer a level that the mask enables, when there is one.
				lvl = LEVEL_W'($urandom_range(0, 7));
				for (int t = 0; t < 8 && !cur_mask[lvl]; t++)
					lvl = LEVEL_W'($urandom_range(0, 7));
				offer_event(lvl, pool_file[pick], pool_line[pick],
					$urandom_range(0, 999) < clear_pm);
			end
		end
		settle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values leave the mask clear: every level passes untouched and
		// a due clear is ignored.
		offer_event(3'd7, '1, '1, 1'b1);
		settle();

		// Limit of one with every level masked. A clear on an empty table
		// gives the verdict alone; the repeated key goes over the limit.
		set_config(16'd1, 16'h00FF);
		offer_event(3'd0, '0, '0, 1'b1);
		offer_event(3'd0, '0, '0, 1'b0);
		offer_event(3'd7, '0, '0, 1'b0);
		offer_event(3'd7, '0, '0, 1'b0);
		offer_event(3'd2, '0, '0, 1'b0);
		// Same file on another line, and same line in another file, are misses.
		offer_event(3'd0, '0, '1, 1'b0);
		offer_event(3'd0, '1, '0, 1'b0);
		offer_event(3'd5, '1, '1, 1'b1);
		settle();

		// Limit of zero, junk in the unused mask bits. Fill the table, lift
		// one entry off zero, then overflow it twice: the ties on the lowest
		// count must evict the earliest such entry each time.
		set_config(16'd0, 16'hA5FF);
		for (int i = 0; i < TABLE_DEPTH_DEF; i++)
			offer_event(LEVEL_W'(i % 8), FILE_W'(32'h5A00_0000 + i), LINE_W'(i), 1'b0);
		offer_event(3'd1, 32'h5A00_0000, 20'd0, 1'b0);
		offer_event(3'd6, 32'h5A00_0100, 20'd16, 1'b0);
		offer_event(3'd6, 32'h5A00_0001, 20'd1, 1'b0);
		offer_event(3'd4, 32'h5A00_0100, 20'd16, 1'b0);
		offer_event(3'd3, '0, '0, 1'b1);
		settle();

		// Random phases over a spread of settings.
		set_config(16'd2, 16'h00FF);
		run_random_phase(90, 24, 30, 10);
		set_config(16'd0, {8'($urandom()), 8'($urandom_range(1, 254))});
		run_random_phase(70, 20, 40, 15);

		// A stretch with no idling at the top limit.
		set_config(16'hFFFF, 16'h00FF);
		tx_free = 1'b1;
		rx_free <= 1'b1;
		run_random_phase(50, 18, 30, 10);
		tx_free = 1'b0;
		rx_free <= 1'b0;

		// Nothing masked: every event passes and the table sits still.
		set_config(16'($urandom_range(1, 6)), {8'($urandom()), 8'h00});
		run_random_phase(30, 16, 100, 20);
		set_config(16'($urandom_range(1, 10)), {8'($urandom()), 8'($urandom())});
		run_random_phase(100, 28, 25, 15);

		// Let any straggler surface before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("repeat_event_suppressor_core_tb: PASS");
		else
			$display("repeat_event_suppressor_core_tb: FAIL");
		$finish;
	end

endmodule : repeat_event_suppressor_core_tb
